### hw/rtl/frct_pkg.sv
package frct_pkg;

   // Fixed field widths
   localparam int ADDR_W     = 48;
   localparam int KIND_W     = 2;
   localparam int COUNT_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int LIMIT_W    = 13;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   // Parameter defaults
   localparam int FRAME_CAPACITY_DEF = 4096;
   localparam int PAGE_SHIFT_DEF     = 12;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Operation kinds
   localparam logic [KIND_W-1:0] KIND_INC  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DEC  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SET  = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNDER = 2'd3;

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'd0;

   // Controller to datapath commands
   typedef struct packed {
      logic clear_step;  // write zero at the clear index, advance it
      logic capture;     // take the request, start the table read
      logic commit;      // update the entry, load the response register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;  // clear index is at the last entry
   } status_type;

endpackage

### hw/rtl/frct_ram.sv
module frct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/frct_ctrl.sv
module frct_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  frct_pkg::status_type status,
   output frct_pkg::cmd_type    cmd
);

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // Response register can take a new result this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == S_IDLE);

   // Commands
   always_comb begin
      cmd.clear_step = (state_ff == S_CLEAR);
      cmd.capture    = (state_ff == S_IDLE) && req_valid;
      cmd.commit     = (state_ff == S_COMMIT) && out_free;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // Response valid: set on commit, dropped when taken
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hw/rtl/frct_datapath.sv
module frct_datapath #(
   parameter int FRAME_CAPACITY = frct_pkg::FRAME_CAPACITY_DEF,
   parameter int PAGE_SHIFT     = frct_pkg::PAGE_SHIFT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  frct_pkg::cmd_type                 cmd,
   output frct_pkg::status_type              status,
   input  logic [frct_pkg::KIND_W-1:0]       req_kind,
   input  logic [frct_pkg::ADDR_W-1:0]       req_phys_addr,
   input  logic [frct_pkg::COUNT_W-1:0]      req_new_count,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [frct_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [frct_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [frct_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic [frct_pkg::COUNT_W-1:0]      rsp_count_value,
   output logic                              rsp_is_shared,
   output logic [frct_pkg::STATUS_W-1:0]     rsp_status
);

   localparam int FN_W    = frct_pkg::ADDR_W - PAGE_SHIFT;
   localparam int FRAME_W = $clog2(FRAME_CAPACITY);

   logic [frct_pkg::LIMIT_W-1:0]   limit_ff;
   logic [FRAME_W-1:0]             clear_idx_ff;
   logic [FRAME_W-1:0]             frame_ff;
   logic [frct_pkg::KIND_W-1:0]    kind_ff;
   logic [frct_pkg::COUNT_W-1:0]   new_count_ff;
   logic                           in_range_ff;
   logic [frct_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                           shared_ff;
   logic [frct_pkg::STATUS_W-1:0]  status_ff, status_in;

   logic [FN_W-1:0]                frame_full;
   logic                           in_range_in;
   logic [frct_pkg::REG_IDX_W-1:0] reg_idx;
   logic                           csr_wr;
   logic                           upd_wr;
   logic                           ram_wr_en;
   logic [FRAME_W-1:0]             ram_wr_addr;
   logic [frct_pkg::COUNT_W-1:0]   ram_wr_data;
   logic [FRAME_W-1:0]             ram_rd_addr;
   logic [frct_pkg::COUNT_W-1:0]   cur;

   // Configuration register
   assign reg_idx = csr_paddr[frct_pkg::CSR_ADDR_W-1:2];
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite
                    && (reg_idx == frct_pkg::REG_FRAMES_IN_USE);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_wr) begin
         limit_ff <= csr_pwdata[frct_pkg::LIMIT_W-1:0];
      end
   end

   assign csr_prdata = (reg_idx == frct_pkg::REG_FRAMES_IN_USE)
                       ? frct_pkg::CSR_DATA_W'(limit_ff) : '0;

   // Clearing pass index
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_idx_ff <= '0;
      end else if (cmd.clear_step) begin
         clear_idx_ff <= clear_idx_ff + FRAME_W'(1);
      end
   end

   assign status.clear_last = (clear_idx_ff == FRAME_W'(FRAME_CAPACITY - 1));

   // Frame number and range check against the limit and the table size
   assign frame_full  = req_phys_addr[frct_pkg::ADDR_W-1:PAGE_SHIFT];
   assign in_range_in = (frame_full < FN_W'(limit_ff))
                        && (frame_full < FN_W'(FRAME_CAPACITY));

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         frame_ff     <= frame_full[FRAME_W-1:0];
         kind_ff      <= req_kind;
         new_count_ff <= req_new_count;
         in_range_ff  <= in_range_in;
      end
   end

   // Read the entry in the accept cycle, then hold the address
   assign ram_rd_addr = cmd.capture ? frame_full[FRAME_W-1:0] : frame_ff;

   frct_ram #(
      .WIDTH (frct_pkg::COUNT_W),
      .DEPTH (FRAME_CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (cur)
   );

   // Entry update
   always_comb begin
      count_in  = cur;
      status_in = frct_pkg::ST_OK;
      upd_wr    = 1'b0;
      if (!in_range_ff) begin
         count_in  = '0;
         status_in = frct_pkg::ST_RANGE;
      end else begin
         case (kind_ff)
            frct_pkg::KIND_INC: begin
               if (cur == frct_pkg::COUNT_MAX) begin
                  status_in = frct_pkg::ST_OVER;
               end else begin
                  count_in = cur + frct_pkg::COUNT_W'(1);
                  upd_wr   = 1'b1;
               end
            end
            frct_pkg::KIND_DEC: begin
               if (cur == '0) begin
                  status_in = frct_pkg::ST_UNDER;
               end else begin
                  count_in = cur - frct_pkg::COUNT_W'(1);
                  upd_wr   = 1'b1;
               end
            end
            frct_pkg::KIND_READ: begin
               count_in = cur;
            end
            frct_pkg::KIND_SET: begin
               count_in = new_count_ff;
               upd_wr   = 1'b1;
            end
            default: begin
               count_in = cur;
            end
         endcase
      end
   end

   // Table write: clearing pass or committed update
   always_comb begin
      if (cmd.clear_step) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_idx_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = cmd.commit && upd_wr;
         ram_wr_addr = frame_ff;
         ram_wr_data = count_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         count_ff  <= count_in;
         shared_ff <= (count_in > frct_pkg::COUNT_W'(1));
         status_ff <= status_in;
      end
   end

   assign rsp_count_value = count_ff;
   assign rsp_is_shared   = shared_ff;
   assign rsp_status      = status_ff;

endmodule

### hw/rtl/frame_reference_count_table.sv
// Reference count table with one 32-bit count per physical page frame.
// Request channel (req_*): kind (increment, decrement, read, set), a
// physical address whose frame is phys_addr >> PAGE_SHIFT, and the count
// that a set stores. Response channel (rsp_*): the resulting count, a
// shared flag (count above one) and a status (ok, frame out of range,
// overflow, underflow). Frames at or beyond csr frames_in_use (address 0)
// or FRAME_CAPACITY return count 0 with the range status.
// Timing: a request is accepted in the idle state; the commit state then
// updates the entry and loads the response register, and only then does
// the block return to idle for the next request. The commit state is
// needed because the table memory has a registered read: the entry is
// read in the accept cycle and updated in the commit state.
// The response sits in an output register: a new request is taken while
// the previous response still waits. If rsp_ready stays low, the block
// holds that request uncommitted and accepts nothing more until it drains.
// Reset: frames_in_use returns to 0 and a clearing pass writes zero to
// every entry, one per cycle; req_ready stays low during the pass while
// configuration writes are taken as usual.
module frame_reference_count_table #(
   parameter int FRAME_CAPACITY = frct_pkg::FRAME_CAPACITY_DEF,
   parameter int PAGE_SHIFT     = frct_pkg::PAGE_SHIFT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [frct_pkg::KIND_W-1:0]       req_kind,
   input  logic [frct_pkg::ADDR_W-1:0]       req_phys_addr,
   input  logic [frct_pkg::COUNT_W-1:0]      req_new_count,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [frct_pkg::COUNT_W-1:0]      rsp_count_value,
   output logic                              rsp_is_shared,
   output logic [frct_pkg::STATUS_W-1:0]     rsp_status,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [frct_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [frct_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [frct_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   frct_pkg::cmd_type    cmd;
   frct_pkg::status_type status;

   assign csr_pready = 1'b1;

   frct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   frct_datapath #(
      .FRAME_CAPACITY (FRAME_CAPACITY),
      .PAGE_SHIFT     (PAGE_SHIFT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_kind),
      .req_phys_addr   (req_phys_addr),
      .req_new_count   (req_new_count),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .rsp_count_value (rsp_count_value),
      .rsp_is_shared   (rsp_is_shared),
      .rsp_status      (rsp_status)
   );

endmodule

### sim/frct_checker.sv
`timescale 1ns / 1ps

// Watches the request, response and register ports of the frame reference
// count table, keeps its own copy of the counts and the frame limit, and
// compares every response with the oldest predicted one.
module frct_checker #(
   parameter int FRAME_CAPACITY = frct_pkg::FRAME_CAPACITY_DEF,
   parameter int PAGE_SHIFT     = frct_pkg::PAGE_SHIFT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [frct_pkg::KIND_W-1:0]     req_kind,
   input  logic [frct_pkg::ADDR_W-1:0]     req_phys_addr,
   input  logic [frct_pkg::COUNT_W-1:0]    req_new_count,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [frct_pkg::COUNT_W-1:0]    rsp_count_value,
   input  logic                            rsp_is_shared,
   input  logic [frct_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [frct_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [frct_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                            csr_pready,
   output int                              mismatches,
   output int                              outstanding,
   output int                              compared
);

   localparam int FRAME_W = $clog2(FRAME_CAPACITY);

   typedef struct packed {
      logic [frct_pkg::COUNT_W-1:0]  count;
      logic                          shared;
      logic [frct_pkg::STATUS_W-1:0] status;
   } count_result_type;

   // Shadow of the count table and the frame limit
   logic [frct_pkg::COUNT_W-1:0] frame_counts [FRAME_CAPACITY];
   logic [frct_pkg::LIMIT_W-1:0] frames_limit;
   count_result_type             pending_counts [$];

   // Applies one request to the shadow table and returns the response it
   // should produce
   function automatic count_result_type update_frame_count(
         input logic [frct_pkg::KIND_W-1:0]  kind,
         input logic [frct_pkg::ADDR_W-1:0]  addr,
         input logic [frct_pkg::COUNT_W-1:0] given);
      logic [frct_pkg::ADDR_W-1:0]  frame;
      logic [frct_pkg::ADDR_W-1:0]  bound;
      logic [FRAME_W-1:0]           idx;
      logic [frct_pkg::COUNT_W-1:0] cur;
      count_result_type             res;
      frame = addr >> PAGE_SHIFT;
      idx   = frame[FRAME_W-1:0];
      // limits above the table size are clamped
      bound = (frames_limit > FRAME_CAPACITY) ? frct_pkg::ADDR_W'(FRAME_CAPACITY)
                                              : frct_pkg::ADDR_W'(frames_limit);
      res.status = frct_pkg::ST_OK;
      if (frame >= bound) begin
         res.count  = '0;
         res.status = frct_pkg::ST_RANGE;
      end else begin
         cur       = frame_counts[idx];
         res.count = cur;
         case (kind)
            frct_pkg::KIND_INC: begin
               if (cur == frct_pkg::COUNT_MAX) begin
                  res.status = frct_pkg::ST_OVER;
               end else begin
                  res.count         = cur + frct_pkg::COUNT_W'(1);
                  frame_counts[idx] = res.count;
               end
            end
            frct_pkg::KIND_DEC: begin
               if (cur == '0) begin
                  res.status = frct_pkg::ST_UNDER;
               end else begin
                  res.count         = cur - frct_pkg::COUNT_W'(1);
                  frame_counts[idx] = res.count;
               end
            end
            frct_pkg::KIND_READ: begin
               res.count = cur;
            end
            default: begin
               res.count         = given;
               frame_counts[idx] = given;
            end
         endcase
      end
      res.shared = (res.count > frct_pkg::COUNT_W'(1));
      return res;
   endfunction

   always @(posedge clock) begin : watch
      count_result_type want;
      if (reset) begin
         for (int i = 0; i < FRAME_CAPACITY; i++) frame_counts[i] = '0;
         frames_limit = '0;
         pending_counts.delete();
         mismatches = 0;
         compared   = 0;
      end else begin
         // response side first: it always belongs to an older request
         if (rsp_valid && rsp_ready) begin
            if (pending_counts.size() == 0) begin
               $error("response with no request waiting: count_value %0h status %0d",
                      rsp_count_value, rsp_status);
               mismatches++;
            end else begin
               want = pending_counts.pop_front();
               compared++;
               if (rsp_count_value !== want.count) begin
                  $error("count_value: expected %0h, got %0h", want.count, rsp_count_value);
                  mismatches++;
               end
               if (rsp_is_shared !== want.shared) begin
                  $error("is_shared: expected %0d, got %0d", want.shared, rsp_is_shared);
                  mismatches++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready)
            pending_counts.push_back(update_frame_count(req_kind, req_phys_addr,
                                                        req_new_count));
         // register writes; indexes beyond the list are ignored
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[frct_pkg::CSR_ADDR_W-1:2] == frct_pkg::REG_FRAMES_IN_USE)
            frames_limit = csr_pwdata[frct_pkg::LIMIT_W-1:0];
      end
      outstanding = pending_counts.size();
   end

endmodule

### sim/tb_frame_reference_count_table.sv
`timescale 1ns / 1ps

module tb_frame_reference_count_table;

   localparam int CAP        = frct_pkg::FRAME_CAPACITY_DEF;
   localparam int SHIFT      = frct_pkg::PAGE_SHIFT_DEF;
   localparam int PERIOD     = 12;
   localparam int LONG_HOLD  = 120;
   localparam int MAX_GAP    = 10;
   localparam int TIMEOUT_NS = 400_000 * PERIOD;

   localparam logic [frct_pkg::CSR_ADDR_W-1:0] FRAMES_ADDR =
      frct_pkg::CSR_ADDR_W'(4 * frct_pkg::REG_FRAMES_IN_USE);
   localparam logic [frct_pkg::CSR_ADDR_W-1:0] UNUSED_REG_ADDR = frct_pkg::CSR_ADDR_W'(4);

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [frct_pkg::KIND_W-1:0]     req_kind = frct_pkg::KIND_INC;
   logic [frct_pkg::ADDR_W-1:0]     req_phys_addr = '0;
   logic [frct_pkg::COUNT_W-1:0]    req_new_count = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [frct_pkg::COUNT_W-1:0]    rsp_count_value;
   logic                            rsp_is_shared;
   logic [frct_pkg::STATUS_W-1:0]   rsp_status;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [frct_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [frct_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [frct_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   int mismatches;
   int outstanding;
   int compared;

   // stimulus bookkeeping
   logic [frct_pkg::LIMIT_W-1:0] limit_now = '0;
   bit                           send_gaps = 1'b1;
   bit                           recv_gaps = 1'b1;
   int                           sent_by_kind [4];
   int                           limit_settings = 0;

   always #(PERIOD / 2) clock = ~clock;

   frame_reference_count_table #(
      .FRAME_CAPACITY (CAP),
      .PAGE_SHIFT     (SHIFT)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_phys_addr   (req_phys_addr),
      .req_new_count   (req_new_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_count_value (rsp_count_value),
      .rsp_is_shared   (rsp_is_shared),
      .rsp_status      (rsp_status),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   frct_checker #(
      .FRAME_CAPACITY (CAP),
      .PAGE_SHIFT     (SHIFT)
   ) count_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_phys_addr   (req_phys_addr),
      .req_new_count   (req_new_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_count_value (rsp_count_value),
      .rsp_is_shared   (rsp_is_shared),
      .rsp_status      (rsp_status),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .compared        (compared)
   );

   // Setup and access cycle; the write lands when penable and pready meet
   task automatic csr_write(input logic [frct_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [frct_pkg::CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr[frct_pkg::CSR_ADDR_W-1:2] == frct_pkg::REG_FRAMES_IN_USE) begin
         limit_now = data[frct_pkg::LIMIT_W-1:0];
         limit_settings++;
      end
   endtask

   // Offers one request after a random gap and waits until it is taken
   task automatic issue(input logic [frct_pkg::KIND_W-1:0]  kind,
                        input logic [frct_pkg::ADDR_W-1:0]  addr,
                        input logic [frct_pkg::COUNT_W-1:0] cnt);
      int gap;
      gap = send_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_phys_addr <= addr;
      req_new_count <= cnt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent_by_kind[kind]++;
   endtask

   // Drops the request and blocks until every predicted response has been seen
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   function automatic logic [frct_pkg::ADDR_W-1:0] frame_addr(
         input logic [frct_pkg::ADDR_W-1:0] frame,
         input int                          offset);
      return (frame << SHIFT) | frct_pkg::ADDR_W'(offset);
   endfunction

   // Mostly a few hot frames so counts climb and hit the limits
   function automatic logic [frct_pkg::ADDR_W-1:0] random_address();
      logic [frct_pkg::ADDR_W-1:0] frame;
      int                          bound;
      int                          pick;
      bound = (limit_now > CAP) ? CAP : int'(limit_now);
      pick  = $urandom_range(0, 99);
      if (bound == 0 || pick >= 85) begin
         frame = frct_pkg::ADDR_W'({$urandom, $urandom}) >> SHIFT;
         if (pick >= 95 || frame < frct_pkg::ADDR_W'(bound)) frame = frct_pkg::ADDR_W'(bound);
      end else if (pick < 70) begin
         case ($urandom_range(0, 5))
            4:       frame = frct_pkg::ADDR_W'(bound - 1);
            5:       frame = (bound > 1) ? frct_pkg::ADDR_W'(bound - 2) : '0;
            default: frame = frct_pkg::ADDR_W'($urandom_range(0,
                                                ((bound < 4) ? bound : 4) - 1));
         endcase
      end else begin
         frame = frct_pkg::ADDR_W'($urandom_range(0, bound - 1));
      end
      return frame_addr(frame, $urandom_range(0, (1 << SHIFT) - 1));
   endfunction

   function automatic logic [frct_pkg::COUNT_W-1:0] random_count();
      case ($urandom_range(0, 4))
         0, 1:    return frct_pkg::COUNT_W'($urandom_range(0, 3));
         2:       return frct_pkg::COUNT_MAX - frct_pkg::COUNT_W'($urandom_range(0, 2));
         default: return $urandom;
      endcase
   endfunction

   // Response side: random stall per response, two long hold-offs
   initial begin : receiver
      int stall;
      int taken;
      taken = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (taken == 250 || taken == 650)
            stall = LONG_HOLD;
         else
            stall = recv_gaps ? $urandom_range(0, MAX_GAP) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
         taken++;
         @(negedge clock);
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      logic [frct_pkg::CSR_DATA_W-1:0] value;
      int                              items;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // limit still zero after reset: everything is out of range
      issue(frct_pkg::KIND_READ, frame_addr(0, 0), random_count());
      issue(frct_pkg::KIND_INC, frame_addr(0, 4), random_count());
      drain();
      csr_write(FRAMES_ADDR, 32'd4096);

      // count walk on one frame: shared flag, back to zero, underflow
      issue(frct_pkg::KIND_INC, frame_addr(0, 0), random_count());
      issue(frct_pkg::KIND_INC, frame_addr(0, 8), random_count());
      issue(frct_pkg::KIND_DEC, frame_addr(0, 0), random_count());
      issue(frct_pkg::KIND_DEC, frame_addr(0, 12), random_count());
      issue(frct_pkg::KIND_DEC, frame_addr(0, 0), random_count());
      issue(frct_pkg::KIND_READ, frame_addr(0, 0), random_count());
      // saturation at all ones
      issue(frct_pkg::KIND_SET, frame_addr(5, 0), frct_pkg::COUNT_MAX);
      issue(frct_pkg::KIND_INC, frame_addr(5, 1), random_count());
      issue(frct_pkg::KIND_READ, frame_addr(5, 2), random_count());
      issue(frct_pkg::KIND_DEC, frame_addr(5, 3), random_count());
      issue(frct_pkg::KIND_SET, frame_addr(CAP - 1, 'hFFF), frct_pkg::COUNT_MAX - 1);
      issue(frct_pkg::KIND_INC, frame_addr(CAP - 1, 0), random_count());
      issue(frct_pkg::KIND_INC, frame_addr(CAP - 1, 0), random_count());
      // out of range: all ones, first frame past the table, set ignored
      issue(frct_pkg::KIND_READ, '1, random_count());
      issue(frct_pkg::KIND_INC, frame_addr(CAP, 0), random_count());
      issue(frct_pkg::KIND_SET, frame_addr(CAP, 0), frct_pkg::COUNT_MAX);
      issue(frct_pkg::KIND_SET, frame_addr(1, 0), 32'd1);
      issue(frct_pkg::KIND_READ, frame_addr(1, 'hFFF), random_count());
      issue(frct_pkg::KIND_SET, frame_addr(2, 0), '0);
      issue(frct_pkg::KIND_DEC, frame_addr(2, 0), random_count());

      // random phases, each with its own limit and idling mix
      for (int ph = 0; ph < 9; ph++) begin
         drain();
         case (ph)
            0:       value = 32'd4096;
            1:       value = 32'hFFFF_FFFF;  // masks to 8191, clamped to the table
            2:       value = 32'd1;
            3:       value = 32'd2;
            4:       value = 32'd37;
            5:       value = 32'd4095;
            6:       value = 32'd5000;
            7:       value = 32'd0;
            default: value = $urandom;
         endcase
         csr_write(FRAMES_ADDR, value);
         send_gaps = (ph % 4 == 0) || (ph % 4 == 1);
         recv_gaps = (ph % 4 == 0) || (ph % 4 == 2);
         items = (value[frct_pkg::LIMIT_W-1:0] == '0) ? 30 : 120;
         for (int n = 0; n < items; n++) begin
            if (n == items / 2) begin
               // hold back until the block has emptied
               drain();
               if (ph == 3) csr_write(UNUSED_REG_ADDR, $urandom);
            end
            issue(frct_pkg::KIND_W'($urandom_range(0, 3)), random_address(),
                  random_count());
         end
      end

      drain();
      repeat (8) @(negedge clock);
      $display("Compared %0d responses; requests: %0d inc, %0d dec, %0d read, %0d set",
               compared, sent_by_kind[frct_pkg::KIND_INC], sent_by_kind[frct_pkg::KIND_DEC],
               sent_by_kind[frct_pkg::KIND_READ], sent_by_kind[frct_pkg::KIND_SET]);
      $display("Frame limit written %0d times (zero, one, full, above capacity, random)",
               limit_settings);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
